// ===== design/tpqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Quiescence detector package
// Shared widths, operation and result codes, and request/result types.
// ----------------------------------------------------------------------------
package tpqd_pkg;

  // Width of the sent and handled counters and of the global sums taken in.
  localparam int unsigned CountWidth = 64;
  // Width of the user sums.
  localparam int unsigned UserWidth  = 64;

  localparam int unsigned FuncWidth  = 3;
  localparam int unsigned AmtWidth   = 32;
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned PhaseWidth = 2;
  localparam int unsigned OutWidth   = 64;

  typedef enum logic [FuncWidth-1:0] {
    FuncBegin   = 3'd0,
    FuncAddSent = 3'd1,
    FuncAddHand = 3'd2,
    FuncEndEp   = 3'd3,
    FuncPoll    = 3'd4,
    FuncResult  = 3'd5
  } func_e;

  typedef enum logic [KindWidth-1:0] {
    KindNone  = 2'd0,
    KindSnap  = 2'd1,
    KindRetry = 2'd2,
    KindTerm  = 2'd3
  } kind_e;

  localparam logic [PhaseWidth-1:0] PhaseOne = 2'd1;
  localparam logic [PhaseWidth-1:0] PhaseTwo = 2'd2;

  typedef struct packed {
    logic [FuncWidth-1:0] func;
    logic [AmtWidth-1:0]  amount;
    logic [UserWidth-1:0] user_delta;
    logic                 transport_idle;
    logic [OutWidth-1:0]  global_handled;
    logic [OutWidth-1:0]  global_sent;
    logic [UserWidth-1:0] global_user;
  } req_t;

  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [OutWidth-1:0]   snap_handled;
    logic [OutWidth-1:0]   snap_sent;
    logic [UserWidth-1:0]  snap_user;
    logic [UserWidth-1:0]  final_user;
    logic [PhaseWidth-1:0] phase_now;
    logic                  count_error;
  } res_t;

endpackage

// ===== design/tpqd_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one detector request.
// ----------------------------------------------------------------------------
interface tpqd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] amount;
  logic [63:0] user_delta;
  logic        transport_idle;
  logic [63:0] global_handled;
  logic [63:0] global_sent;
  logic [63:0] global_user;

  modport source (
    output valid, func, amount, user_delta, transport_idle,
           global_handled, global_sent, global_user,
    input  ready
  );

  modport sink (
    input  valid, func, amount, user_delta, transport_idle,
           global_handled, global_sent, global_user,
    output ready
  );
endinterface

// ===== design/tpqd_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one detector result.
// ----------------------------------------------------------------------------
interface tpqd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] snap_handled;
  logic [63:0] snap_sent;
  logic [63:0] snap_user;
  logic [63:0] final_user;
  logic [1:0]  phase_now;
  logic        count_error;

  modport source (
    output valid, kind, snap_handled, snap_sent, snap_user, final_user,
           phase_now, count_error,
    input  ready
  );

  modport sink (
    input  valid, kind, snap_handled, snap_sent, snap_user, final_user,
           phase_now, count_error,
    output ready
  );
endinterface

// ===== design/tpqd_core.sv =====
// ----------------------------------------------------------------------------
// Quiescence detector core
// Detector state and the update that one request causes.
// ----------------------------------------------------------------------------
module tpqd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  tpqd_pkg::req_t req_i,
  output tpqd_pkg::res_t res_o
);
  import tpqd_pkg::*;

  logic                  done_q, done_d;
  logic                  detecting_q, detecting_d;
  logic [CountWidth-1:0] handled_q, handled_d;
  logic [CountWidth-1:0] sent_q, sent_d;
  logic [UserWidth-1:0]  user_q, user_d;
  logic [CountWidth-1:0] last_gsent_q, last_gsent_d;
  logic [CountWidth-1:0] prev_sent_q, prev_sent_d;
  logic                  start_pend_q, start_pend_d;
  logic                  reduce_q, reduce_d;
  logic                  phase_two_q, phase_two_d;

  logic [CountWidth-1:0] g_handled;
  logic [CountWidth-1:0] g_sent;

  assign g_handled = CountWidth'(req_i.global_handled);
  assign g_sent    = CountWidth'(req_i.global_sent);

  always_comb begin
    done_d       = done_q;
    detecting_d  = detecting_q;
    handled_d    = handled_q;
    sent_d       = sent_q;
    user_d       = user_q;
    last_gsent_d = last_gsent_q;
    prev_sent_d  = prev_sent_q;
    start_pend_d = start_pend_q;
    reduce_d     = reduce_q;
    phase_two_d  = phase_two_q;
    res_o        = '0;

    unique case (req_i.func)
      FuncBegin: begin
        done_d      = 1'b0;
        detecting_d = 1'b0;
        handled_d   = '0;
        sent_d      = '0;
        user_d      = '0;
      end
      FuncAddSent: begin
        sent_d = sent_q + CountWidth'(req_i.amount);
      end
      FuncAddHand: begin
        handled_d = handled_q + CountWidth'(req_i.amount);
      end
      FuncEndEp: begin
        if (!done_q) begin
          user_d       = user_q + req_i.user_delta;
          last_gsent_d = '0;
          start_pend_d = 1'b1;
          reduce_d     = 1'b0;
          phase_two_d  = 1'b0;
          prev_sent_d  = '0;
          detecting_d  = 1'b1;
        end
      end
      FuncPoll: begin
        if (req_i.transport_idle && !done_q && detecting_q && start_pend_q) begin
          prev_sent_d        = last_gsent_q;
          res_o.snap_handled = OutWidth'(handled_q);
          res_o.snap_sent    = OutWidth'(sent_q);
          res_o.snap_user    = user_q;
          reduce_d           = 1'b1;
          start_pend_d       = 1'b0;
          res_o.kind         = KindSnap;
        end
      end
      FuncResult: begin
        if (reduce_q && !done_q && detecting_q) begin
          reduce_d          = 1'b0;
          last_gsent_d      = g_sent;
          res_o.count_error = (prev_sent_q > g_sent);
          if (g_handled != g_sent) begin
            phase_two_d  = 1'b0;
            start_pend_d = 1'b1;
            res_o.kind   = KindRetry;
          end else if (!phase_two_q || (g_sent != prev_sent_q)) begin
            phase_two_d  = 1'b1;
            start_pend_d = 1'b1;
            res_o.kind   = KindRetry;
          end else begin
            done_d           = 1'b1;
            handled_d        = '0;
            sent_d           = '0;
            res_o.final_user = req_i.global_user;
            res_o.kind       = KindTerm;
          end
        end
      end
      default: begin
      end
    endcase

    res_o.phase_now = phase_two_d ? PhaseTwo : PhaseOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q       <= 1'b1;
      detecting_q  <= 1'b0;
      handled_q    <= '0;
      sent_q       <= '0;
      user_q       <= '0;
      last_gsent_q <= '0;
      prev_sent_q  <= '0;
      start_pend_q <= 1'b0;
      reduce_q     <= 1'b0;
      phase_two_q  <= 1'b0;
    end else if (fire_i) begin
      done_q       <= done_d;
      detecting_q  <= detecting_d;
      handled_q    <= handled_d;
      sent_q       <= sent_d;
      user_q       <= user_d;
      last_gsent_q <= last_gsent_d;
      prev_sent_q  <= prev_sent_d;
      start_pend_q <= start_pend_d;
      reduce_q     <= reduce_d;
      phase_two_q  <= phase_two_d;
    end
  end

endmodule

// ===== design/two_phase_quiescence_detector.sv =====
// Path: an accepted request waits in the request register until the result
// register is free; the core's result is then registered for the sink to take.
// Throughput: one request per cycle when the sink keeps up, set by the state
// update in the core between the request register and the result register.
// Reset: asynchronous, active low; the detector comes up terminated, in
// phase one, with all counts and sums cleared and both registers empty.
// ----------------------------------------------------------------------------
// Two-phase quiescence detector
// One node of a counting termination detector with a request register, an
// update core and a result register.
// ----------------------------------------------------------------------------
module two_phase_quiescence_detector (
  input  logic clk_i,
  input  logic rst_ni,
  tpqd_req_if.sink   in_i,
  tpqd_res_if.source out_o
);
  import tpqd_pkg::*;

  // Request register: holds one accepted request until the core takes it.
  logic s1_valid_q;
  req_t s1_req_q;

  // Result register: holds one finished result until the sink takes it.
  logic out_valid_q;
  res_t out_res_q;

  res_t core_res;
  logic out_free;
  logic fire;
  logic take_in;

  // The core runs whenever a request is waiting and the result register can
  // take its result in the same edge (empty, or being emptied now).
  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = s1_valid_q && out_free;

  // A new request may enter while the previous one moves on, so the block
  // sustains one request per cycle when the sink keeps up.
  assign in_i.ready = !s1_valid_q || fire;
  assign take_in    = in_i.valid && in_i.ready;

  tpqd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (s1_req_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_req_q.func           <= in_i.func;
      s1_req_q.amount         <= in_i.amount;
      s1_req_q.user_delta     <= in_i.user_delta;
      s1_req_q.transport_idle <= in_i.transport_idle;
      s1_req_q.global_handled <= in_i.global_handled;
      s1_req_q.global_sent    <= in_i.global_sent;
      s1_req_q.global_user    <= in_i.global_user;
    end
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_res_q.kind;
  assign out_o.snap_handled = out_res_q.snap_handled;
  assign out_o.snap_sent    = out_res_q.snap_sent;
  assign out_o.snap_user    = out_res_q.snap_user;
  assign out_o.final_user   = out_res_q.final_user;
  assign out_o.phase_now    = out_res_q.phase_now;
  assign out_o.count_error  = out_res_q.count_error;

endmodule
